@@ rtl/tsc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and functions for the thermometer scratchpad checker.
// No dependencies; imported by every module under rtl/.
package tsc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned RES_W    = 2;
    localparam int unsigned DEG_W    = 12;
    localparam int unsigned OUT_W    = 16;

    localparam logic [BYTE_W-1:0] CRC_POLY  = 8'h8C;
    localparam logic [RES_W-1:0]  RES_12BIT = 2'd3;
    localparam logic signed [DEG_W-1:0] LIMIT_HIGH = 12'sd200;
    localparam logic signed [DEG_W-1:0] LIMIT_LOW  = -12'sd200;

    typedef enum logic [1:0] {
        STATUS_OK  = 2'd0,
        STATUS_CRC = 2'd1,
        STATUS_RES = 2'd2
    } status_t;

    // one received scratchpad byte
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } in_item_t;

    // result word, packed as it leaves on tdata
    typedef struct packed {
        logic                    pad;
        logic                    in_range;
        logic signed [DEG_W-1:0] degrees;
        status_t                 status;
    } result_t;

    // reflected CRC-8, LSB first, one whole byte per call
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] crc;
        logic              fb;
        crc = crc_in;
        for (int i = 0; i < BYTE_W; i++)
        begin
            fb  = crc[0] ^ b[i];
            crc = crc >> 1;
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

@@ rtl/tsc_in_stage.sv @@
`timescale 1ns / 1ps
// Input register: takes one byte word per cycle from the stream unless stalled.
// Depends on tsc_pkg.
module tsc_in_stage
    import tsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     stg_valid,
    input  logic     stg_take,
    output in_item_t stg_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || stg_take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload: load on every accepted word
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign stg_valid = valid_reg;
    assign stg_item  = item_reg;

endmodule

@@ rtl/tsc_decode.sv @@
`timescale 1ns / 1ps
// Frame state (CRC, byte position, raw temperature) and the result register.
// Depends on tsc_pkg.
module tsc_decode
    import tsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [RES_W-1:0] resolution_mode,
    input  logic             stg_valid,
    output logic             stg_take,
    input  in_item_t         stg_item,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res_word
);

    logic [BYTE_W-1:0] crc_reg, crc_next;
    logic [1:0]        pos_reg, pos_next;
    logic [BYTE_W-1:0] raw_low_reg, raw_low_next;
    logic [BYTE_W-1:0] raw_high_reg, raw_high_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic                    out_free;
    logic                    emit;
    logic [BYTE_W-1:0]       crc_new;
    logic [BYTE_W-1:0]       low_eff;
    logic [BYTE_W-1:0]       high_eff;
    logic signed [15:0]      raw_word;
    logic signed [15:0]      raw_adj;
    logic signed [DEG_W-1:0] deg;

    assign out_free = !out_valid_reg || res_ready;
    // a non-final byte never blocks on the output side
    assign stg_take = stg_valid && (!stg_item.last_byte || out_free);
    assign emit     = stg_take && stg_item.last_byte;

    assign crc_new  = crc8_byte(crc_reg, stg_item.data_byte);
    assign low_eff  = (pos_reg == 2'd0) ? stg_item.data_byte : raw_low_reg;
    assign high_eff = (pos_reg == 2'd1) ? stg_item.data_byte : raw_high_reg;
    assign raw_word = $signed({high_eff, low_eff});
    // bias negatives by 15 so the shift truncates toward zero
    assign raw_adj  = raw_word + $signed({12'd0, {4{raw_word[15]}}});
    assign deg      = raw_adj[15:4];

    always_comb
    begin
        crc_next       = crc_reg;
        pos_next       = pos_reg;
        raw_low_next   = raw_low_reg;
        raw_high_next  = raw_high_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;

        if (stg_take)
        begin
            crc_next      = crc_new;
            raw_low_next  = low_eff;
            raw_high_next = high_eff;
            if (pos_reg != 2'd2)
            begin
                pos_next = pos_reg + 2'd1;
            end
        end

        if (emit)
        begin
            out_valid_next    = 1'b1;
            out_next.pad      = 1'b0;
            out_next.degrees  = '0;
            out_next.in_range = 1'b0;
            if (crc_new != '0)
            begin
                out_next.status = STATUS_CRC;
            end
            else if (resolution_mode != RES_12BIT)
            begin
                out_next.status = STATUS_RES;
            end
            else
            begin
                out_next.status   = STATUS_OK;
                out_next.degrees  = deg;
                out_next.in_range = (deg >= LIMIT_LOW) && (deg <= LIMIT_HIGH);
            end
            // clear the frame for the next scratchpad
            crc_next      = '0;
            pos_next      = 2'd0;
            raw_low_next  = '0;
            raw_high_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= '0;
            pos_reg       <= 2'd0;
            raw_low_reg   <= '0;
            raw_high_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            pos_reg       <= pos_next;
            raw_low_reg   <= raw_low_next;
            raw_high_reg  <= raw_high_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res_word  = out_reg;

endmodule

@@ rtl/thermometer_scratchpad_checker.sv @@
`timescale 1ns / 1ps
// Top level of the thermometer scratchpad checker: resolution register,
// input stage and decode stage. Depends on tsc_pkg, tsc_in_stage, tsc_decode.
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+---------------------------------------
//   s_axis   | s_axis_tvalid / s_axis_tready  | tdata[7:0] data_byte, tlast last_byte
//   m_axis   | m_axis_tvalid / m_axis_tready  | tdata: status, degrees, in_range
//   cfg      | cfg_we                         | cfg_wdata[1:0] resolution_mode
//
// One byte per clock unless stalled; CRC update and byte capture are one byte-wide step.
// A final byte reaches its result through the input register and then the result register.
// Reset clears the CRC, byte position, raw word and sets 12-bit resolution. A stalled result holds
// only final bytes; non-final bytes keep flowing until a held final byte blocks the input stream.
module thermometer_scratchpad_checker
    import tsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  logic              s_axis_tlast,   // last_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // [1:0] status, [13:2] degrees, [14] in_range
    input  logic              cfg_we,
    input  logic [RES_W-1:0]  cfg_wdata
);

    logic [RES_W-1:0] resolution_reg;
    in_item_t         in_item;
    in_item_t         stg_item;
    logic             stg_valid;
    logic             stg_take;
    result_t          res_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg <= RES_12BIT;
        end
        else if (cfg_we)
        begin
            resolution_reg <= cfg_wdata;
        end
    end

    assign in_item.data_byte = s_axis_tdata;
    assign in_item.last_byte = s_axis_tlast;

    tsc_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .stg_valid (stg_valid),
        .stg_take  (stg_take),
        .stg_item  (stg_item)
    );

    tsc_decode u_decode (
        .clk             (clk),
        .rst_n           (rst_n),
        .resolution_mode (resolution_reg),
        .stg_valid       (stg_valid),
        .stg_take        (stg_take),
        .stg_item        (stg_item),
        .res_valid       (m_axis_tvalid),
        .res_ready       (m_axis_tready),
        .res_word        (res_word)
    );

    assign m_axis_tdata = res_word;

endmodule

@@ rtl/tsc_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for the thermometer scratchpad checker, bound to the top.
// Depends on tsc_pkg and thermometer_scratchpad_checker.
module tsc_checker
    import tsc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              s_axis_tlast,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_W-1:0]  m_axis_tdata
);

    logic [1:0]              st;
    logic signed [DEG_W-1:0] dg;
    logic                    ir;

    assign st = m_axis_tdata[1:0];
    assign dg = $signed(m_axis_tdata[13:2]);
    assign ir = m_axis_tdata[14];

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (st == STATUS_OK || st == STATUS_CRC || st == STATUS_RES))
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && st != STATUS_OK |-> dg == '0 && !ir)
        else $error("failed frame carries temperature");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && st == STATUS_OK |-> ir == ((dg >= LIMIT_LOW) && (dg <= LIMIT_HIGH)))
        else $error("in_range flag disagrees with degrees");

    // a rising result valid must be preceded by a final byte taken, a final byte offered, or input back-pressure
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2)
            || $past(!s_axis_tready || (s_axis_tvalid && s_axis_tlast), 1))
        else $error("result without a final byte");

endmodule

bind thermometer_scratchpad_checker tsc_checker u_tsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
